// File: design/tfpd_pkg.sv
// Shared types and constants for the tile frame pixel decoder.
`default_nettype none
package tfpd_pkg;

   typedef enum logic [0:0] {
      CMD_PALETTE = 1'b0,
      CMD_BYTE    = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      FT_SQUARE      = 3'd0,
      FT_TRANSPARENT = 3'd1,
      FT_LEFT_TRI    = 3'd2,
      FT_RIGHT_TRI   = 3'd3,
      FT_LEFT_TRAP   = 3'd4,
      FT_RIGHT_TRAP  = 3'd5,
      FT_UNUSED6     = 3'd6,
      FT_UNUSED7     = 3'd7
   } frame_kind_type;

   localparam int unsigned TILE_DIM   = 32;
   localparam logic [4:0]  LAST_ROW   = 5'd31;
   localparam logic [4:0]  TRI_LAST   = 5'd30;
   localparam logic [4:0]  HALF_ROW   = 5'd16;
   localparam logic [1:0]  ROW_SKIP   = 2'd2;
   localparam logic [7:0]  ALPHA_OPAQ = 8'd255;

   typedef struct packed {
      logic       valid;
      logic       pix;
      logic [4:0] x;
      logic [4:0] y;
      logic       done;
   } result_type;

endpackage
`default_nettype wire

// File: design/tfpd_ifs.sv
// Valid/ready channel interfaces for request and response items.
`default_nettype none
interface tfpd_req_if;
   logic        valid;
   logic        ready;
   logic [0:0]  command;
   logic [7:0]  palette_index;
   logic [23:0] palette_color;
   logic [2:0]  frame_type;
   logic [7:0]  data_byte;
   logic        first_byte;
   logic        last_byte;
   modport source (output valid, command, palette_index, palette_color, frame_type,
                   data_byte, first_byte, last_byte, input ready);
   modport sink (input valid, command, palette_index, palette_color, frame_type,
                 data_byte, first_byte, last_byte, output ready);
endinterface

interface tfpd_rsp_if;
   logic        valid;
   logic        ready;
   logic        pixel_valid;
   logic [4:0]  pixel_x;
   logic [4:0]  pixel_y;
   logic [31:0] pixel_color;
   logic        frame_done;
   modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_color, frame_done,
                   input ready);
   modport sink (input valid, pixel_valid, pixel_x, pixel_y, pixel_color, frame_done,
                 output ready);
endinterface
`default_nettype wire

// File: design/tfpd_palette.sv
// Palette RAM: 256 x 24 entries, registered read, RGBA resolve.
`default_nettype none
module tfpd_palette (
   input  wire logic        clock,
   input  wire logic        wr_en,
   input  wire logic [7:0]  wr_addr,
   input  wire logic [23:0] wr_data,
   input  wire logic        rd_en,
   input  wire logic [7:0]  rd_addr,
   output      logic [31:0] rd_color
);
   logic [23:0] mem [256];
   logic [23:0] rd_data_ff;
   logic        rd_zero_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_zero_ff <= (rd_addr == 8'd0);
      end
   end

   assign rd_color = rd_zero_ff ? 32'd0 : {tfpd_pkg::ALPHA_OPAQ, rd_data_ff};
endmodule
`default_nettype wire

// File: design/tile_frame_pixel_decoder_core.sv
// Tile frame pixel decoder top level: byte decode, palette lookup, result register.
// Usage:
//   req channel carries palette writes (command 0) and frame bytes (command 1).
//   Palette entries must be written before frame bytes refer to them.
//   A frame byte with first_byte set latches frame_type and restarts decoding.
//   rsp channel carries at most one item per frame byte: a pixel write, or a
//   frame_done marker with pixel_valid low when the last byte draws nothing.
// Latency: a result is presented the cycle after its byte is accepted; the
//   palette RAM read and the result register form that one stage.
// Throughput: one item per cycle while rsp.ready is high; decode state lives in
//   registers updated in the accept cycle, so consecutive bytes need no bubble.
// Stall: while a result waits on rsp.ready low, req.ready is low; once the
//   receiver takes it, a new item is accepted in that same cycle.
// Reset: synchronous, clears decode state to the start of a square frame and
//   empties the result register. Palette contents are undefined until written.
`default_nettype none
module tile_frame_pixel_decoder_core (
   input  wire logic   clock,
   input  wire logic   reset,
   tfpd_req_if.sink    req_ch,
   tfpd_rsp_if.source  rsp_ch
);
   logic [2:0] type_ff,  type_in;
   logic [4:0] row_ff,   row_in;
   logic [5:0] col_ff,   col_in;
   logic [5:0] width_ff, width_in;
   logic [1:0] skip_ff,  skip_in;
   logic [6:0] run_ff,   run_in;
   logic       phase_ff, phase_in;
   logic       fin_ff,   fin_in;

   tfpd_pkg::result_type res_ff, res_in;

   logic        accept;
   logic        is_byte;
   logic        pal_wr;
   logic [31:0] color;

   assign req_ch.ready = !res_ff.valid || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_byte      = (req_ch.command == tfpd_pkg::CMD_BYTE);
   assign pal_wr       = accept && !is_byte;

   always_comb begin
      logic [2:0] t;
      logic [7:0] b;
      logic [7:0] neg;
      logic [8:0] nx;
      logic [5:0] base;
      logic [5:0] col_nx;
      logic [4:0] last;
      logic       adv;
      logic       pix;
      logic [4:0] px;
      t      = req_ch.first_byte ? req_ch.frame_type : type_ff;
      b      = req_ch.data_byte;
      row_in = req_ch.first_byte ? 5'd0 : row_ff;
      col_in = req_ch.first_byte ? 6'd0 : col_ff;
      width_in = req_ch.first_byte ? 6'd0 : width_ff;
      skip_in  = req_ch.first_byte ? 2'd0 : skip_ff;
      run_in   = req_ch.first_byte ? 7'd0 : run_ff;
      phase_in = req_ch.first_byte ? 1'b0 : phase_ff;
      fin_in   = req_ch.first_byte ? 1'b0 : fin_ff;
      type_in  = t;
      neg    = 8'(9'd256 - {1'b0, b});
      nx     = 9'd0;
      base   = 6'd0;
      col_nx = 6'd0;
      adv    = 1'b0;
      pix    = 1'b0;
      px     = 5'd0;
      last   = ((t == tfpd_pkg::FT_LEFT_TRI) || (t == tfpd_pkg::FT_RIGHT_TRI))
               ? tfpd_pkg::TRI_LAST : tfpd_pkg::LAST_ROW;
      if (!fin_in && (t <= tfpd_pkg::FT_RIGHT_TRAP)) begin
         if (t == tfpd_pkg::FT_TRANSPARENT) begin
            last = tfpd_pkg::LAST_ROW;
            if (!phase_in) begin
               if (b == 8'd0) begin
                  adv = 1'b1;
               end else if (!b[7]) begin
                  run_in   = b[6:0];
                  phase_in = 1'b1;
               end else begin
                  nx = 9'({3'd0, col_in} + {1'b0, neg});
                  if (nx >= 9'(tfpd_pkg::TILE_DIM)) begin
                     adv = 1'b1;
                  end else begin
                     col_in = nx[5:0];
                  end
               end
            end else begin
               pix    = 1'b1;
               px     = col_in[4:0];
               col_in = col_in + 6'd1;
               run_in = run_in - 7'd1;
               if (col_in >= 6'(tfpd_pkg::TILE_DIM)) begin
                  adv = 1'b1;
               end else if (run_in == 7'd0) begin
                  phase_in = 1'b0;
               end
            end
         end else begin
            if (width_in == 6'd0) begin
               col_in  = 6'd0;
               skip_in = 2'd0;
               if (t == tfpd_pkg::FT_SQUARE) begin
                  width_in = 6'(tfpd_pkg::TILE_DIM);
               end else if (row_in < tfpd_pkg::HALF_ROW) begin
                  width_in = {1'b0, row_in} + 6'd1;
                  width_in = {width_in[4:0], 1'b0};
                  skip_in  = row_in[0] ? 2'd0 : tfpd_pkg::ROW_SKIP;
               end else if ((t == tfpd_pkg::FT_LEFT_TRAP) ||
                            (t == tfpd_pkg::FT_RIGHT_TRAP)) begin
                  width_in = 6'(tfpd_pkg::TILE_DIM);
               end else begin
                  width_in = (row_in <= tfpd_pkg::TRI_LAST)
                             ? {(tfpd_pkg::LAST_ROW - row_in), 1'b0} : 6'd2;
                  if (t == tfpd_pkg::FT_LEFT_TRI) begin
                     skip_in = row_in[0] ? 2'd0 : tfpd_pkg::ROW_SKIP;
                  end else begin
                     skip_in = (row_in[0] && (row_in < tfpd_pkg::TRI_LAST))
                               ? tfpd_pkg::ROW_SKIP : 2'd0;
                  end
               end
            end
            if (skip_in != 2'd0) begin
               skip_in = skip_in - 2'd1;
            end else begin
               if (((t == tfpd_pkg::FT_LEFT_TRI) || (t == tfpd_pkg::FT_LEFT_TRAP)) &&
                   !((t == tfpd_pkg::FT_LEFT_TRAP) && (row_in >= tfpd_pkg::HALF_ROW))) begin
                  base = 6'(tfpd_pkg::TILE_DIM) - width_in;
               end
               col_nx = base + col_in;
               pix    = 1'b1;
               px     = col_nx[4:0];
               col_in = col_in + 6'd1;
               if (col_in >= width_in) begin
                  adv = 1'b1;
               end
            end
         end
      end
      if (adv) begin
         col_in   = 6'd0;
         run_in   = 7'd0;
         phase_in = 1'b0;
         width_in = 6'd0;
         if (row_in >= last) begin
            fin_in = 1'b1;
         end else begin
            row_in = row_in + 5'd1;
         end
      end
      res_in.valid = pix || req_ch.last_byte;
      res_in.pix   = pix;
      res_in.x     = pix ? px : 5'd0;
      res_in.y     = pix ? (tfpd_pkg::LAST_ROW - (req_ch.first_byte ? 5'd0 : row_ff)) : 5'd0;
      res_in.done  = req_ch.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff      <= 3'd0;
         row_ff       <= 5'd0;
         col_ff       <= 6'd0;
         width_ff     <= 6'd0;
         skip_ff      <= 2'd0;
         run_ff       <= 7'd0;
         phase_ff     <= 1'b0;
         fin_ff       <= 1'b0;
         res_ff.valid <= 1'b0;
      end else begin
         if (accept && is_byte) begin
            type_ff  <= type_in;
            row_ff   <= row_in;
            col_ff   <= col_in;
            width_ff <= width_in;
            skip_ff  <= skip_in;
            run_ff   <= run_in;
            phase_ff <= phase_in;
            fin_ff   <= fin_in;
         end
         if (accept) begin
            res_ff.valid <= is_byte && res_in.valid;
         end else if (rsp_ch.ready) begin
            res_ff.valid <= 1'b0;
         end
      end
      if (accept) begin
         res_ff.pix  <= res_in.pix;
         res_ff.x    <= res_in.x;
         res_ff.y    <= res_in.y;
         res_ff.done <= res_in.done;
      end
   end

   tfpd_palette u_palette (
      .clock    (clock),
      .wr_en    (pal_wr),
      .wr_addr  (req_ch.palette_index),
      .wr_data  (req_ch.palette_color),
      .rd_en    (accept && is_byte),
      .rd_addr  (req_ch.data_byte),
      .rd_color (color)
   );

   assign rsp_ch.valid       = res_ff.valid;
   assign rsp_ch.pixel_valid = res_ff.pix;
   assign rsp_ch.pixel_x     = res_ff.x;
   assign rsp_ch.pixel_y     = res_ff.y;
   assign rsp_ch.pixel_color = res_ff.pix ? color : 32'd0;
   assign rsp_ch.frame_done  = res_ff.done;

   a_nopix_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.pixel_valid |-> rsp_ch.frame_done && (rsp_ch.pixel_color == 32'd0))
      else $error("result without pixel must be a frame_done marker");

   a_palette_no_result: assert property (@(posedge clock) disable iff (reset)
      pal_wr |=> !rsp_ch.valid)
      else $error("palette write produced a result");

   a_finished_no_pixel: assert property (@(posedge clock) disable iff (reset)
      accept && is_byte && !req_ch.first_byte && fin_ff |=> !(rsp_ch.valid && rsp_ch.pixel_valid))
      else $error("pixel emitted after shape finished");

endmodule
`default_nettype wire

// File: tb/tile_frame_pixel_decoder_core_tb.sv
// Self-checking testbench for the tile frame pixel decoder core.
module tile_frame_pixel_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RESET_CYCLES    = 12;
   localparam int unsigned STALL_LIMIT     = 3000;
   localparam int unsigned LONG_HOLD       = 300;
   localparam int unsigned PHASE_ITEMS     = 350;
   localparam int unsigned LEFT_TRI_BYTES  = 544;
   localparam int unsigned RIGHT_TRI_BYTES = 542;
   localparam int unsigned TRAP_BYTES      = 800;

   typedef struct packed {
      tfpd_pkg::command_type    cmd;
      logic [7:0]               pal_idx;
      logic [23:0]              pal_rgb;
      tfpd_pkg::frame_kind_type kind;
      logic [7:0]               data;
      logic                     sof;
      logic                     eof;
   } decoder_item_type;

   typedef struct packed {
      logic        pixel_valid;
      logic [4:0]  x;
      logic [4:0]  y;
      logic [31:0] color;
      logic        done;
   } pixel_write_type;

   logic clock;
   logic reset;

   tfpd_req_if req_bus ();
   tfpd_rsp_if rsp_bus ();

   tile_frame_pixel_decoder_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   decoder_item_type byte_stream[$];
   pixel_write_type  pixel_writes_due[$];
   pixel_write_type  predicted;
   pixel_write_type  got;
   pixel_write_type  want;

   int unsigned queued_total   = 0;
   int unsigned mismatches     = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned hold_left      = 0;
   bit          long_hold_done = 0;
   int          burst_phase    = 0;
   int          tx_idle_pct    = 26;
   int          rx_idle_pct    = 84;

   // decoder mirror state
   logic [23:0]              pal_table [256];
   tfpd_pkg::frame_kind_type cur_kind   = tfpd_pkg::FT_SQUARE;
   int unsigned              src_row    = 0;
   int unsigned              col_pos    = 0;
   int unsigned              row_len    = 0;
   int unsigned              skip_cnt   = 0;
   int unsigned              lit_cnt    = 0;
   bit                       in_literal = 0;
   bit                       frame_over = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void close_row(input int unsigned end_row);
      col_pos    = 0;
      lit_cnt    = 0;
      in_literal = 0;
      row_len    = 0;
      if (src_row >= end_row) frame_over = 1;
      else src_row++;
   endfunction

   function automatic bit decode_frame_item(input decoder_item_type it,
                                            output pixel_write_type px);
      bit          drew;
      int unsigned nx;
      int unsigned base;
      logic [4:0]  row_y;
      px   = '0;
      drew = 0;
      if (it.cmd == tfpd_pkg::CMD_PALETTE) begin
         pal_table[it.pal_idx] = it.pal_rgb;
         return 0;
      end
      if (it.sof) begin
         cur_kind   = it.kind;
         src_row    = 0;
         col_pos    = 0;
         row_len    = 0;
         skip_cnt   = 0;
         lit_cnt    = 0;
         in_literal = 0;
         frame_over = 0;
      end
      if (!frame_over && cur_kind <= tfpd_pkg::FT_RIGHT_TRAP) begin
         row_y = tfpd_pkg::LAST_ROW - 5'(src_row);
         if (cur_kind == tfpd_pkg::FT_TRANSPARENT) begin
            if (!in_literal) begin
               if (it.data == 8'd0) begin
                  close_row(tfpd_pkg::LAST_ROW);
               end else if (!it.data[7]) begin
                  lit_cnt    = it.data;
                  in_literal = 1;
               end else begin
                  nx = col_pos + (256 - it.data);
                  if (nx >= tfpd_pkg::TILE_DIM) close_row(tfpd_pkg::LAST_ROW);
                  else col_pos = nx;
               end
            end else begin
               drew = 1;
               px.x = 5'(col_pos);
               col_pos++;
               lit_cnt = (lit_cnt - 1) & 127;
               if (col_pos >= tfpd_pkg::TILE_DIM) close_row(tfpd_pkg::LAST_ROW);
               else if (lit_cnt == 0) in_literal = 0;
            end
         end else begin
            if (row_len == 0) begin
               row_len  = tfpd_pkg::TILE_DIM;
               skip_cnt = 0;
               if (cur_kind != tfpd_pkg::FT_SQUARE) begin
                  if (src_row < tfpd_pkg::HALF_ROW) begin
                     row_len  = 2 * (src_row + 1);
                     skip_cnt = src_row[0] ? 0 : tfpd_pkg::ROW_SKIP;
                  end else if (cur_kind == tfpd_pkg::FT_LEFT_TRAP ||
                               cur_kind == tfpd_pkg::FT_RIGHT_TRAP) begin
                     row_len = tfpd_pkg::TILE_DIM;
                  end else begin
                     row_len = (src_row <= tfpd_pkg::TRI_LAST) ?
                               2 * (tfpd_pkg::LAST_ROW - src_row) : 2;
                     if (cur_kind == tfpd_pkg::FT_LEFT_TRI)
                        skip_cnt = src_row[0] ? 0 : tfpd_pkg::ROW_SKIP;
                     else
                        skip_cnt = (src_row[0] && src_row < tfpd_pkg::TRI_LAST) ?
                                   tfpd_pkg::ROW_SKIP : 0;
                  end
               end
               col_pos = 0;
            end
            if (skip_cnt > 0) begin
               skip_cnt--;
            end else begin
               // left triangle rows and the top half of a left trapezoid hug the right edge
               base = (cur_kind == tfpd_pkg::FT_LEFT_TRI ||
                       (cur_kind == tfpd_pkg::FT_LEFT_TRAP && src_row < tfpd_pkg::HALF_ROW)) ?
                      tfpd_pkg::TILE_DIM - row_len : 0;
               drew = 1;
               px.x = 5'(base + col_pos);
               col_pos++;
               if (col_pos >= row_len)
                  close_row((cur_kind == tfpd_pkg::FT_LEFT_TRI ||
                             cur_kind == tfpd_pkg::FT_RIGHT_TRI) ?
                            tfpd_pkg::TRI_LAST : tfpd_pkg::LAST_ROW);
            end
         end
      end
      if (drew) begin
         px.pixel_valid = 1'b1;
         px.y           = row_y;
         px.color       = (it.data == 8'd0) ? 32'd0 :
                          {tfpd_pkg::ALPHA_OPAQ, pal_table[it.data]};
      end
      px.done = it.eof;
      return drew || it.eof;
   endfunction

   function automatic logic [7:0] pick_index();
      return ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom);
   endfunction

   task automatic queue_palette(input logic [7:0] idx, input logic [23:0] rgb);
      decoder_item_type it;
      it.cmd     = tfpd_pkg::CMD_PALETTE;
      it.pal_idx = idx;
      it.pal_rgb = rgb;
      it.kind    = tfpd_pkg::frame_kind_type'($urandom_range(7));
      it.data    = 8'($urandom);
      it.sof     = $urandom_range(1);
      it.eof     = $urandom_range(1);
      byte_stream = {byte_stream, it};
      queued_total++;
   endtask

   task automatic queue_byte(input tfpd_pkg::frame_kind_type kind, input logic [7:0] data,
                             input bit sof, input bit eof);
      decoder_item_type it;
      it.cmd     = tfpd_pkg::CMD_BYTE;
      it.pal_idx = 8'($urandom);
      it.pal_rgb = 24'($urandom);
      it.kind    = kind;
      it.data    = data;
      it.sof     = sof;
      it.eof     = eof;
      byte_stream = {byte_stream, it};
      queued_total++;
   endtask

   // builds a well-formed frame, then either keeps it whole with a few trailing
   // bytes or cuts it short
   task automatic queue_frame(input tfpd_pkg::frame_kind_type kind, input bit whole);
      logic [7:0]  enc[$];
      int unsigned n;
      int unsigned s;
      int unsigned col;
      bit          lead;
      if (kind == tfpd_pkg::FT_TRANSPARENT) begin
         for (int row = 0; row < tfpd_pkg::TILE_DIM; row++) begin
            col = 0;
            if ($urandom_range(3) != 0) begin
               if ($urandom_range(1)) enc = {enc, 8'h00};
               else enc = {enc, 8'(256 - $urandom_range(128, tfpd_pkg::TILE_DIM))};
            end else begin
               while (col < tfpd_pkg::TILE_DIM) begin
                  case ($urandom_range(7))
                     0: begin
                        enc = {enc, 8'h00};
                        col = tfpd_pkg::TILE_DIM;
                     end
                     1, 2: begin
                        s = ($urandom_range(3) == 0) ?
                            $urandom_range(128, tfpd_pkg::TILE_DIM - col) :
                            $urandom_range(tfpd_pkg::TILE_DIM - col, 1);
                        enc = {enc, 8'(256 - s)};
                        col += s;
                     end
                     default: begin
                        n = ($urandom_range(4) == 0) ?
                            $urandom_range(127, tfpd_pkg::TILE_DIM - col) :
                            $urandom_range(tfpd_pkg::TILE_DIM - col, 1);
                        enc = {enc, 8'(n)};
                        if (n > tfpd_pkg::TILE_DIM - col) n = tfpd_pkg::TILE_DIM - col;
                        repeat (n) enc = {enc, pick_index()};
                        col += n;
                     end
                  endcase
               end
            end
         end
      end else begin
         case (kind)
            tfpd_pkg::FT_SQUARE:    n = tfpd_pkg::TILE_DIM * tfpd_pkg::TILE_DIM;
            tfpd_pkg::FT_LEFT_TRI:  n = LEFT_TRI_BYTES;
            tfpd_pkg::FT_RIGHT_TRI: n = RIGHT_TRI_BYTES;
            tfpd_pkg::FT_LEFT_TRAP, tfpd_pkg::FT_RIGHT_TRAP: n = TRAP_BYTES;
            default:                n = $urandom_range(40, 1);
         endcase
         repeat (n) enc = {enc, pick_index()};
      end
      if (whole) begin
         repeat ($urandom_range(3)) enc = {enc, 8'($urandom)};
      end else begin
         n = ($urandom_range(5) == 0) ? $urandom_range(400, 1) : $urandom_range(48, 1);
         while (enc.size() > n) void'(enc.pop_back());
      end
      lead = ($urandom_range(9) != 0);
      foreach (enc[i]) begin
         if ($urandom_range(23) == 0) queue_palette(8'($urandom), 24'($urandom));
         queue_byte((i == 0) ? kind : tfpd_pkg::frame_kind_type'($urandom_range(7)), enc[i],
                    i == 0 && lead, i == enc.size() - 1 || $urandom_range(39) == 0);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (byte_stream.size() != 0 || pixel_writes_due.size() != 0);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.command       <= tfpd_pkg::CMD_PALETTE;
         req_bus.palette_index <= '0;
         req_bus.palette_color <= '0;
         req_bus.frame_type    <= tfpd_pkg::FT_SQUARE;
         req_bus.data_byte     <= '0;
         req_bus.first_byte    <= 1'b0;
         req_bus.last_byte     <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (decode_frame_item(byte_stream[0], predicted))
               pixel_writes_due = {pixel_writes_due, predicted};
            void'(byte_stream.pop_front());
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (byte_stream.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_bus.valid         <= 1'b1;
               req_bus.command       <= byte_stream[0].cmd;
               req_bus.palette_index <= byte_stream[0].pal_idx;
               req_bus.palette_color <= byte_stream[0].pal_rgb;
               req_bus.frame_type    <= byte_stream[0].kind;
               req_bus.data_byte     <= byte_stream[0].data;
               req_bus.first_byte    <= byte_stream[0].sof;
               req_bus.last_byte     <= byte_stream[0].eof;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.pixel_valid, rsp_bus.pixel_x, rsp_bus.pixel_y,
                   rsp_bus.pixel_color, rsp_bus.frame_done};
            if (pixel_writes_due.size() == 0) begin
               $display("%0t unexpected item: v=%0b x=%0d y=%0d c=%h done=%0b", $time,
                        got.pixel_valid, got.x, got.y, got.color, got.done);
               mismatches++;
            end else begin
               want = pixel_writes_due.pop_front();
               if (got !== want) begin
                  $display("%0t mismatch: expected v=%0b x=%0d y=%0d c=%h done=%0b", $time,
                           want.pixel_valid, want.x, want.y, want.color, want.done);
                  $display("%0t             actual v=%0b x=%0d y=%0d c=%h done=%0b", $time,
                           got.pixel_valid, got.x, got.y, got.color, got.done);
                  mismatches++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!long_hold_done && burst_phase == 2 && rsp_bus.valid) begin
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
            rsp_bus.ready  <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // bytes straight after reset decode as a square frame
      queue_byte(tfpd_pkg::FT_RIGHT_TRAP, 8'h00, 0, 0);
      queue_byte(tfpd_pkg::FT_UNUSED7, 8'h00, 0, 1);
      for (int i = 0; i < 256; i++)
         queue_palette(8'(i), (i == 1) ? 24'hFFFFFF : (i == 2) ? 24'h000000 : 24'($urandom));
      queue_byte(tfpd_pkg::FT_SQUARE, 8'hFF, 1, 0);
      // unknown types draw nothing
      queue_byte(tfpd_pkg::FT_UNUSED6, 8'hAB, 1, 1);
      queue_byte(tfpd_pkg::FT_UNUSED7, 8'h12, 1, 0);
      // transparent: literal run, skip, skip past the edge, end of row
      queue_byte(tfpd_pkg::FT_TRANSPARENT, 8'h02, 1, 0);
      queue_byte(tfpd_pkg::FT_SQUARE, 8'hFF, 0, 0);
      queue_byte(tfpd_pkg::FT_SQUARE, 8'h00, 0, 0);
      queue_byte(tfpd_pkg::FT_SQUARE, 8'hFE, 0, 0);
      queue_byte(tfpd_pkg::FT_SQUARE, 8'h80, 0, 0);
      queue_byte(tfpd_pkg::FT_SQUARE, 8'h00, 0, 1);
      // triangle row prefix skips, one of them closing the frame
      queue_byte(tfpd_pkg::FT_LEFT_TRI, 8'h33, 1, 0);
      queue_byte(tfpd_pkg::FT_SQUARE, 8'h44, 0, 1);
      queue_byte(tfpd_pkg::FT_SQUARE, 8'h55, 0, 0);
      queue_byte(tfpd_pkg::FT_SQUARE, 8'h00, 0, 0);
      queue_byte(tfpd_pkg::FT_RIGHT_TRI, 8'h66, 1, 0);
      queue_byte(tfpd_pkg::FT_SQUARE, 8'h77, 0, 0);
      queue_byte(tfpd_pkg::FT_SQUARE, 8'h88, 0, 0);
      queue_byte(tfpd_pkg::FT_LEFT_TRAP, 8'h01, 1, 1);
      queue_byte(tfpd_pkg::FT_RIGHT_TRAP, 8'h02, 1, 0);
      queue_palette(8'd1, 24'h00FF00);
      queue_byte(tfpd_pkg::FT_SQUARE, 8'h01, 1, 1);
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         int unsigned phase_start;
         tfpd_pkg::frame_kind_type pick;
         burst_phase = ph;
         case (ph)
            0: begin
               tx_idle_pct = 26;
               rx_idle_pct = 84;
            end
            1: begin
               tx_idle_pct = 84;
               rx_idle_pct = 26;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         phase_start = queued_total;
         if (ph == 0)
            queue_frame($urandom_range(1) ? tfpd_pkg::FT_LEFT_TRI : tfpd_pkg::FT_LEFT_TRAP, 1);
         else if (ph == 1)
            queue_frame($urandom_range(1) ? tfpd_pkg::FT_RIGHT_TRI : tfpd_pkg::FT_RIGHT_TRAP, 1);
         while (queued_total - phase_start < PHASE_ITEMS) begin
            pick = tfpd_pkg::frame_kind_type'($urandom_range(7));
            queue_frame(pick, (pick == tfpd_pkg::FT_TRANSPARENT ||
                               pick >= tfpd_pkg::FT_UNUSED6) && $urandom_range(1));
         end
         wait_drained();
      end

      repeat (4) @(negedge clock);
      if (mismatches == 0 && pixel_writes_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
